// File: rtl/utf8_byte_stream_decoder_core_macros.svh
// Assertion macros used by the decoder RTL.
// Each macro expects signals named clk and rst in the including module.
`ifndef UTF8_BYTE_STREAM_DECODER_CORE_MACROS_SVH
`define UTF8_BYTE_STREAM_DECODER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define U8DEC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define U8DEC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/u8dec_pkg.sv
package u8dec_pkg;

  localparam int unsigned CpWidth  = 31;
  localparam int unsigned RemWidth = 3;

  localparam logic [7:0] ContMask = 8'hC0;
  localparam logic [7:0] ContTag  = 8'h80;
  localparam logic [7:0] Lead2    = 8'hC0;
  localparam logic [7:0] Lead3    = 8'hE0;
  localparam logic [7:0] Lead4    = 8'hF0;
  localparam logic [7:0] Lead5    = 8'hF8;
  localparam logic [7:0] Lead6    = 8'hFC;
  localparam logic [7:0] DataMask = 8'h3F;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       string_end;
  } in_beat_t;

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               error;
    logic               last_of_string;
  } result_t;

  // Number of continuation bytes that a lead byte announces.
  function automatic logic [RemWidth-1:0] lead_count(input logic [7:0] b);
    logic [RemWidth-1:0] n;
    n = '0;
    if (b >= Lead2) n = RemWidth'(1);
    if (b >= Lead3) n = RemWidth'(2);
    if (b >= Lead4) n = RemWidth'(3);
    if (b >= Lead5) n = RemWidth'(4);
    if (b >= Lead6) n = RemWidth'(5);
    return n;
  endfunction

  // Payload bits that a lead byte keeps.
  function automatic logic [7:0] lead_mask(input logic [RemWidth-1:0] n);
    logic [7:0] m;
    case (n)
      RemWidth'(1): m = 8'h1F;
      RemWidth'(2): m = 8'h0F;
      RemWidth'(3): m = 8'h07;
      RemWidth'(4): m = 8'h03;
      RemWidth'(5): m = 8'h01;
      default:      m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/u8dec_if.sv
interface u8dec_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       string_end;

  modport source (output valid, output byte_in, output string_end, input ready);
  modport sink (input valid, input byte_in, input string_end, output ready);
endinterface

interface u8dec_code_if;
  logic                              valid;
  logic                              ready;
  logic [u8dec_pkg::CpWidth-1:0]     code_point;
  logic                              error;
  logic                              last_of_string;

  modport source (output valid, output code_point, output error,
                  output last_of_string, input ready);
  modport sink (input valid, input code_point, input error,
                input last_of_string, output ready);
endinterface

// File: rtl/u8dec_in_stage.sv
module u8dec_in_stage (
  input  logic                clk,
  input  logic                rst,
  u8dec_byte_if.sink          bytes,
  input  logic                adv,
  output logic                held,
  output u8dec_pkg::in_beat_t beat
);

  logic take;

  // A new beat may enter whenever the register is empty or being drained.
  assign bytes.ready = !held || adv;
  assign take        = bytes.valid && bytes.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (adv) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      beat.byte_in    <= bytes.byte_in;
      beat.string_end <= bytes.string_end;
    end
  end

endmodule

// File: rtl/u8dec_decode.sv
`include "utf8_byte_stream_decoder_core_macros.svh"

module u8dec_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  u8dec_pkg::in_beat_t beat,
  output logic                has_result,
  output u8dec_pkg::result_t  res
);

  logic [u8dec_pkg::CpWidth-1:0]  partial_code, partial_code_next;
  logic [u8dec_pkg::RemWidth-1:0] bytes_remaining, bytes_remaining_next;
  logic                           dropping, dropping_next;

  logic                           is_cont;
  logic [u8dec_pkg::RemWidth-1:0] count;
  logic [u8dec_pkg::RemWidth-1:0] rem_dec;
  logic [u8dec_pkg::CpWidth-1:0]  shifted;
  logic                           last;

  assign last    = beat.string_end;
  assign is_cont = (beat.byte_in & u8dec_pkg::ContMask) == u8dec_pkg::ContTag;
  assign count   = u8dec_pkg::lead_count(beat.byte_in);
  assign rem_dec = bytes_remaining - u8dec_pkg::RemWidth'(1);
  assign shifted = {partial_code[u8dec_pkg::CpWidth-7:0],
                    beat.byte_in[5:0] & u8dec_pkg::DataMask[5:0]};

  always_comb begin
    partial_code_next    = partial_code;
    bytes_remaining_next = bytes_remaining;
    dropping_next        = dropping;
    has_result           = 1'b0;
    res.code_point       = '0;
    res.error            = 1'b0;
    res.last_of_string   = last;

    if (dropping) begin
      if (last) begin
        dropping_next        = 1'b0;
        partial_code_next    = '0;
        bytes_remaining_next = '0;
      end
    end else if (bytes_remaining == '0) begin
      if (!beat.byte_in[7]) begin
        has_result     = 1'b1;
        res.code_point = u8dec_pkg::CpWidth'(beat.byte_in);
      end else if (is_cont || last) begin
        // A stray continuation byte, or a lead byte that ends the string.
        has_result           = 1'b1;
        res.error            = 1'b1;
        dropping_next        = !last;
        partial_code_next    = '0;
        bytes_remaining_next = '0;
      end else begin
        partial_code_next    = u8dec_pkg::CpWidth'(beat.byte_in & u8dec_pkg::lead_mask(count));
        bytes_remaining_next = count;
      end
    end else if (!is_cont) begin
      has_result           = 1'b1;
      res.error            = 1'b1;
      dropping_next        = !last;
      partial_code_next    = '0;
      bytes_remaining_next = '0;
    end else if (rem_dec == '0) begin
      has_result           = 1'b1;
      res.code_point       = shifted;
      partial_code_next    = '0;
      bytes_remaining_next = '0;
    end else if (last) begin
      // The string ends before the sequence is complete.
      has_result           = 1'b1;
      res.error            = 1'b1;
      partial_code_next    = '0;
      bytes_remaining_next = '0;
    end else begin
      partial_code_next    = shifted;
      bytes_remaining_next = rem_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_code    <= '0;
      bytes_remaining <= '0;
      dropping        <= 1'b0;
    end else if (adv) begin
      partial_code    <= partial_code_next;
      bytes_remaining <= bytes_remaining_next;
      dropping        <= dropping_next;
    end
  end

  `U8DEC_ASSERT_SAME(a_drop_clear, dropping, (bytes_remaining == '0) && (partial_code == '0), "sequence state left over while dropping")
  `U8DEC_ASSERT_SAME(a_idle_clear, bytes_remaining == '0, partial_code == '0, "partial code kept with no sequence open")
  `U8DEC_ASSERT_SAME(a_drop_silent, adv && dropping, !has_result, "result produced while dropping")
  `U8DEC_ASSERT_NEXT(a_error_drops, adv && res.error && has_result && !last, dropping, "error did not start dropping")

endmodule

// File: rtl/u8dec_out_stage.sv
module u8dec_out_stage (
  input  logic               clk,
  input  logic               rst,
  u8dec_code_if.source       codes,
  input  logic               adv,
  input  logic               has_result,
  input  u8dec_pkg::result_t res,
  output logic               free
);

  logic valid;

  assign free        = !valid || codes.ready;
  assign codes.valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= has_result;
    end else if (codes.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && has_result) begin
      codes.code_point     <= res.code_point;
      codes.error          <= res.error;
      codes.last_of_string <= res.last_of_string;
    end
  end

endmodule

// File: rtl/utf8_byte_stream_decoder_core.sv
// UTF-8 byte stream decoder.
// Channel bytes carries one raw byte per beat, with string_end set on the
// last byte of each string. Channel codes carries at most one result per
// input byte: a finished code point, or one error beat for a malformed
// string, after which the remaining bytes of that string are dropped and
// give no beat. last_of_string repeats string_end of the causing byte.
// A byte is taken into the input register, is decoded into the result
// register when the pipeline advances, and is then visible to the receiver.
// Throughput is one byte per cycle while the receiver keeps up, set by the
// single decode step that updates the partial code and the remaining count.
// When the receiver stalls, the result register holds its beat; one more
// byte is still taken into the input register, and further bytes wait.
// Synchronous reset empties both registers and clears the sequence state
// and the dropping flag; no beat is presented during reset.
module utf8_byte_stream_decoder_core (
  input  logic          clk,
  input  logic          rst,
  u8dec_byte_if.sink    bytes,
  u8dec_code_if.source  codes
);

  logic                held;
  logic                free;
  logic                adv;
  logic                has_result;
  u8dec_pkg::in_beat_t beat;
  u8dec_pkg::result_t  res;

  assign adv = held && free;

  u8dec_in_stage u_in (
    .clk  (clk),
    .rst  (rst),
    .bytes(bytes),
    .adv  (adv),
    .held (held),
    .beat (beat)
  );

  u8dec_decode u_dec (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .beat      (beat),
    .has_result(has_result),
    .res       (res)
  );

  u8dec_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .codes     (codes),
    .adv       (adv),
    .has_result(has_result),
    .res       (res),
    .free      (free)
  );

endmodule

// File: test/tb_utf8_byte_stream_decoder_core.sv
`timescale 1ns / 1ps

class code_scoreboard;
  u8dec_pkg::result_t pending_codes[$];
  logic [30:0]      gathered;
  logic [2:0]       conts_left;
  bit               skipping;
  int unsigned      mismatches;
  int unsigned      live_bytes;
  int unsigned      code_beats;
  int unsigned      error_beats;

  function new();
    gathered   = '0;
    conts_left = '0;
    skipping   = 1'b0;
  endfunction

  task report(input string what);
    if (mismatches < 30) $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatches++;
  endtask

  function void push_code(input logic [30:0] cp, input logic bad, input logic last);
    u8dec_pkg::result_t r;
    r.code_point     = cp;
    r.error          = bad;
    r.last_of_string = last;
    pending_codes = {pending_codes, r};
  endfunction

  function void malformed(input logic last);
    gathered   = '0;
    conts_left = '0;
    skipping   = !last;
    push_code('0, 1'b1, last);
  endfunction

  // Called for every byte the decoder accepts.
  function void note_byte(input logic [7:0] b, input logic last);
    logic       is_cont;
    logic [2:0] n;
    is_cont = (b & u8dec_pkg::ContMask) == u8dec_pkg::ContTag;
    live_bytes++;
    if (skipping) begin
      if (last) begin
        skipping   = 1'b0;
        gathered   = '0;
        conts_left = '0;
      end
      return;
    end
    if (conts_left == 0) begin
      if (!b[7]) begin
        push_code({23'd0, b}, 1'b0, last);
      end else if (is_cont) begin
        malformed(last);
      end else begin
        n = 3'd0;
        if (b >= u8dec_pkg::Lead2) n++;
        if (b >= u8dec_pkg::Lead3) n++;
        if (b >= u8dec_pkg::Lead4) n++;
        if (b >= u8dec_pkg::Lead5) n++;
        if (b >= u8dec_pkg::Lead6) n++;
        if (last) begin
          malformed(1'b1);
        end else begin
          gathered   = {23'd0, b & (8'hFF >> (n + 3'd2))};
          conts_left = n;
        end
      end
    end else if (!is_cont) begin
      malformed(last);
    end else begin
      gathered   = {gathered[24:0], b[5:0]};
      conts_left = conts_left - 3'd1;
      if (conts_left == 0) begin
        push_code(gathered, 1'b0, last);
        gathered = '0;
      end else if (last) begin
        malformed(1'b1);
      end
    end
  endfunction

  task check_code(input u8dec_pkg::result_t got);
    u8dec_pkg::result_t want;
    if (pending_codes.size() == 0) begin
      report($sformatf("unexpected beat cp=%h err=%b last=%b",
                       got.code_point, got.error, got.last_of_string));
      return;
    end
    want = pending_codes.pop_front();
    if (got.error) error_beats++;
    else code_beats++;
    if (got.code_point !== want.code_point)
      report($sformatf("code_point %h, expected %h", got.code_point, want.code_point));
    if (got.error !== want.error)
      report($sformatf("error %b, expected %b", got.error, want.error));
    if (got.last_of_string !== want.last_of_string)
      report($sformatf("last_of_string %b, expected %b",
                       got.last_of_string, want.last_of_string));
  endtask
endclass

module tb_utf8_byte_stream_decoder_core;
  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned PhaseBytes   = 615;
  localparam int unsigned HoldCycles   = 120;
  localparam int unsigned DrainCycles  = 8;

  logic clk = 1'b0;
  logic rst;

  u8dec_byte_if bytes_if ();
  u8dec_code_if codes_if ();

  utf8_byte_stream_decoder_core DUT (
    .clk   (clk),
    .rst   (rst),
    .bytes (bytes_if),
    .codes (codes_if)
  );

  code_scoreboard sb = new();

  int unsigned sender_idle_pct;
  int unsigned receiver_idle_pct;
  int unsigned cycle_count;
  int unsigned strings_sent;
  logic        hold_armed;
  int unsigned hold_left;
  bit          hold_done;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("utf8_byte_stream_decoder_core regression: fail");
      $finish;
    end
  end

  // Receiver: checks every accepted beat, then picks the next ready.
  always @(posedge clk) begin
    u8dec_pkg::result_t got;
    if (rst) begin
      codes_if.ready <= 1'b0;
    end else begin
      if (codes_if.valid && codes_if.ready) begin
        got.code_point     = codes_if.code_point;
        got.error          = codes_if.error;
        got.last_of_string = codes_if.last_of_string;
        sb.check_code(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        codes_if.ready <= 1'b0;
      end else if (hold_armed && !hold_done) begin
        // One long hold-off so the decoder backs up into its input.
        hold_done = 1'b1;
        hold_left = HoldCycles;
        codes_if.ready <= 1'b0;
      end else begin
        codes_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  task send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      bytes_if.valid <= 1'b0;
      @(posedge clk);
    end
    bytes_if.valid      <= 1'b1;
    bytes_if.byte_in    <= b;
    bytes_if.string_end <= last;
    do @(posedge clk); while (!bytes_if.ready);
    sb.note_byte(b, last);
  endtask

  task send_run(input logic [7:0] run[$]);
    for (int i = 0; i < run.size(); i++) send_byte(run[i], i == run.size() - 1);
    strings_sent++;
  endtask

  task automatic add_code_point(ref logic [7:0] run[$]);
    int unsigned pick;
    int unsigned conts;
    pick = $urandom_range(9);
    if (pick < 4) begin
      run = {run, 8'($urandom_range(8'h7F))};
      return;
    end
    case (pick)
      4, 5: begin conts = 1; run = {run, 8'($urandom_range(8'hDF, 8'hC0))}; end
      6:    begin conts = 2; run = {run, 8'($urandom_range(8'hEF, 8'hE0))}; end
      7:    begin conts = 3; run = {run, 8'($urandom_range(8'hF7, 8'hF0))}; end
      8:    begin conts = 4; run = {run, 8'($urandom_range(8'hFB, 8'hF8))}; end
      default: begin conts = 5; run = {run, 8'($urandom_range(8'hFF, 8'hFC))}; end
    endcase
    repeat (conts) run = {run, 8'h80 | 8'($urandom_range(8'h3F))};
  endtask

  // Mostly well-formed strings, some damaged ones, and a little raw noise.
  task automatic send_random_string();
    logic [7:0]  run[$];
    int unsigned kind;
    int unsigned spot;
    kind = $urandom_range(99);
    if (kind >= 90) begin
      repeat ($urandom_range(8, 1)) run = {run, 8'($urandom_range(8'hFF))};
    end else begin
      repeat ($urandom_range(6, 1)) add_code_point(run);
      if (kind >= 70) begin
        spot = $urandom_range(run.size() - 1);
        case ($urandom_range(2))
          0: run.insert(spot, 8'h80 | 8'($urandom_range(8'h3F)));
          1: run[spot] = 8'($urandom_range(8'hFF));
          default: while (run.size() > spot + 1) void'(run.pop_back());
        endcase
      end
    end
    send_run(run);
  endtask

  initial begin
    logic [7:0] run[$];
    rst                 = 1'b1;
    bytes_if.valid      = 1'b0;
    bytes_if.byte_in    = 8'h00;
    bytes_if.string_end = 1'b0;
    codes_if.ready      = 1'b0;
    hold_armed          = 1'b0;
    hold_left           = 0;
    hold_done           = 1'b0;
    cycle_count         = 0;
    strings_sent        = 0;
    sender_idle_pct     = 18;
    receiver_idle_pct   = 54;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed strings: ASCII extremes, a two-byte form, the largest six-byte
    // code point, a stray continuation followed by a dropped byte, a lead
    // interrupted by ASCII, and strings that end on a lead or mid-sequence.
    run = {8'h00, 8'h7F};                                 send_run(run);
    run = {8'hC2, 8'hA9};                                 send_run(run);
    run = {8'hFF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF};     send_run(run);
    run = {8'h80, 8'h41};                                 send_run(run);
    run = {8'hE2, 8'h41};                                 send_run(run);
    run = {8'hF0};                                        send_run(run);
    run = {8'hF8, 8'h80};                                 send_run(run);
    run = {8'hFE, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80};     send_run(run);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 18; receiver_idle_pct = 54; end
        1: begin sender_idle_pct = 54; receiver_idle_pct = 18; end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
          hold_armed <= 1'b1;
        end
      endcase
      while (sb.live_bytes < (phase + 1) * PhaseBytes) send_random_string();
    end
    bytes_if.valid <= 1'b0;

    while (sb.pending_codes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Decoded %0d bytes in %0d strings across three idling phases.",
             sb.live_bytes, strings_sent);
    $display("Checked %0d code points and %0d error beats, with a %0d-cycle hold-off.",
             sb.code_beats, sb.error_beats, HoldCycles);
    if (sb.mismatches == 0) begin
      $display("utf8_byte_stream_decoder_core regression: pass");
    end else begin
      $display("utf8_byte_stream_decoder_core regression: fail");
    end
    $finish;
  end
endmodule
